// ===== src/hrp_pkg.sv =====
// Shared types and constants for the hex record parser.
package hrp_pkg;

  // Queue sizes between the parts of the block
  localparam int CmdDepth = 4;
  localparam int CmdPtrW  = $clog2(CmdDepth);
  localparam int CmdCntW  = $clog2(CmdDepth + 1);
  localparam int ResDepth = 4;
  localparam int ResPtrW  = $clog2(ResDepth);
  localparam int ResCntW  = $clog2(ResDepth + 1);

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_END      = 3'd1;
  localparam logic [2:0] ERR_COLON    = 3'd2;
  localparam logic [2:0] ERR_HEX      = 3'd3;
  localparam logic [2:0] ERR_NEWLINE  = 3'd4;
  localparam logic [2:0] ERR_CHECKSUM = 3'd5;

  localparam logic [15:0] LINE_MAX  = 16'hffff;
  localparam logic [7:0]  TYPE_EOF  = 8'h01;

  // Parser phase
  typedef enum logic [2:0] {
    PH_COLON    = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_ADDRESS  = 3'd2,
    PH_TYPE     = 3'd3,
    PH_DATA     = 3'd4,
    PH_CHECKSUM = 3'd5,
    PH_NEWLINE  = 3'd6,
    PH_WHITE    = 3'd7
  } phase_t;

  // One classified character
  typedef struct packed {
    logic       eoi;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_colon;
    logic       is_lf;
    logic       is_cr;
    logic       is_space;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] byte_address;
    logic [7:0]  record_type;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic        last;
  } res_t;

  // Queue fill levels, reported to the top level
  typedef struct packed {
    logic [CmdCntW-1:0] cmd_count;
    logic [ResCntW-1:0] res_count;
  } hrp_status_t;

endpackage

// ===== src/hrp_front.sv =====
// Front part: classifies characters and holds them in a short queue.
module hrp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          char_in,
  input  logic                end_of_input,
  output logic                cmd_valid,
  output hrp_pkg::cmd_t       cmd,
  input  logic                cmd_pop,
  output logic [hrp_pkg::CmdCntW-1:0] cmd_count
);
  import hrp_pkg::*;

  cmd_t               q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr;
  logic [CmdPtrW-1:0] rd_ptr;
  logic [CmdCntW-1:0] count;
  logic [CmdCntW-1:0] count_next;
  cmd_t               cls;
  logic               take;
  logic               give;

  // Character classification
  always_comb begin
    cls          = '0;
    cls.eoi      = end_of_input;
    cls.is_colon = (char_in == 8'h3a);
    cls.is_lf    = (char_in == 8'h0a);
    cls.is_cr    = (char_in == 8'h0d);
    cls.is_space = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0d);
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = char_in[3:0];
    end else if ((char_in >= 8'h61 && char_in <= 8'h66) ||
                 (char_in >= 8'h41 && char_in <= 8'h46)) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = char_in[3:0] + 4'd9;
    end
  end

  assign full      = (count == CmdCntW'(CmdDepth));
  assign take      = push && !full;
  assign cmd_valid = (count != '0);
  assign give      = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];
  assign cmd_count = count;

  always_comb begin
    count_next = count;
    if (take && !give) count_next = count + CmdCntW'(1);
    if (!take && give) count_next = count - CmdCntW'(1);
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) wr_ptr <= wr_ptr + CmdPtrW'(1);
      if (give) rd_ptr <= rd_ptr + CmdPtrW'(1);
      count <= count_next;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (take) q[wr_ptr] <= cls;
  end

endmodule

// ===== src/hrp_back.sv =====
// Back part: record parser state machine, up to two results per character.
module hrp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  hrp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          room,
  output logic [1:0]    res_n,
  output hrp_pkg::res_t res0,
  output hrp_pkg::res_t res1
);
  import hrp_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  digits_left, digits_left_next;
  logic [15:0] accumulator, accumulator_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  type_value, type_value_next;
  logic [7:0]  data_index, data_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] line_count, line_count_next;
  logic        stopped, stopped_next;

  logic        fire;
  logic        act;
  logic [15:0] acc_shift;
  logic [2:0]  dl_dec;
  logic [7:0]  v;
  logic [15:0] line_cur;

  function automatic res_t mk_res(logic [1:0] kind, logic [15:0] addr, logic [7:0] typ,
                                  logic [7:0] data, logic [2:0] err, logic [15:0] line,
                                  logic lst);
    res_t r;
    r.kind         = kind;
    r.byte_address = addr;
    r.record_type  = typ;
    r.data_byte    = data;
    r.error_code   = err;
    r.line_number  = line;
    r.last         = lst;
    return r;
  endfunction

  assign fire      = cmd_valid && room;
  assign cmd_pop   = fire;
  assign act       = fire && !stopped;
  assign acc_shift = {accumulator[11:0], cmd.hex_val};
  assign dl_dec    = digits_left - 3'd1;
  assign v         = acc_shift[7:0];
  assign line_cur  = (!cmd.eoi && cmd.is_lf && line_count != LINE_MAX) ?
                     line_count + 16'd1 : line_count;

  // Next-state logic
  always_comb begin
    phase_next          = phase;
    digits_left_next    = digits_left;
    accumulator_next    = accumulator;
    record_length_next  = record_length;
    record_address_next = record_address;
    type_value_next     = type_value;
    data_index_next     = data_index;
    running_sum_next    = running_sum;
    line_count_next     = line_count;
    stopped_next        = stopped;
    if (act) begin
      line_count_next = line_cur;
      if (cmd.eoi) begin
        // every end of input halts, with or without a record result first
        stopped_next = 1'b1;
      end else begin
        unique case (phase)
          PH_COLON: begin
            if (!cmd.is_colon) begin
              stopped_next = 1'b1;
            end else begin
              phase_next       = PH_LENGTH;
              digits_left_next = 3'd2;
              accumulator_next = '0;
              running_sum_next = '0;
            end
          end
          PH_LENGTH, PH_ADDRESS, PH_TYPE, PH_DATA, PH_CHECKSUM: begin
            if (!cmd.is_hex) begin
              stopped_next = 1'b1;
            end else if (dl_dec != 3'd0) begin
              accumulator_next = acc_shift;
              digits_left_next = dl_dec;
            end else begin
              accumulator_next = '0;
              digits_left_next = 3'd2;
              unique case (phase)
                PH_LENGTH: begin
                  record_length_next = v;
                  running_sum_next   = running_sum + v;
                  phase_next         = PH_ADDRESS;
                  digits_left_next   = 3'd4;
                end
                PH_ADDRESS: begin
                  record_address_next = acc_shift;
                  running_sum_next    = running_sum + acc_shift[15:8] + acc_shift[7:0];
                  phase_next          = PH_TYPE;
                end
                PH_TYPE: begin
                  type_value_next  = v;
                  running_sum_next = running_sum + v;
                  data_index_next  = '0;
                  phase_next       = (record_length == 8'd0) ? PH_CHECKSUM : PH_DATA;
                end
                PH_DATA: begin
                  running_sum_next = running_sum + v;
                  data_index_next  = data_index + 8'd1;
                  if (data_index + 8'd1 == record_length) phase_next = PH_CHECKSUM;
                end
                default: begin
                  running_sum_next = running_sum + v;
                  phase_next       = PH_NEWLINE;
                end
              endcase
            end
          end
          PH_NEWLINE: begin
            if (cmd.is_lf || cmd.is_cr) phase_next = PH_WHITE;
            else stopped_next = 1'b1;
          end
          PH_WHITE: begin
            if (!cmd.is_space) begin
              // close the record, then the same character opens the next one
              if (running_sum != 8'd0 || type_value == TYPE_EOF || !cmd.is_colon) begin
                stopped_next = 1'b1;
              end else begin
                phase_next       = PH_LENGTH;
                digits_left_next = 3'd2;
                accumulator_next = '0;
                running_sum_next = '0;
              end
            end
          end
          default: stopped_next = 1'b1;
        endcase
      end
    end
  end

  // Result logic
  always_comb begin
    res_n = 2'd0;
    res0  = '0;
    res1  = '0;
    if (act) begin
      if (cmd.eoi) begin
        if (phase == PH_WHITE) begin
          if (running_sum != 8'd0) begin
            res0  = mk_res(KIND_ERROR, record_address, type_value, 8'd0, ERR_CHECKSUM,
                           line_cur, 1'b1);
            res_n = 2'd1;
          end else if (type_value == TYPE_EOF) begin
            res0  = mk_res(KIND_RECORD, record_address, type_value, 8'd0, ERR_NONE,
                           line_cur, 1'b1);
            res_n = 2'd1;
          end else begin
            res0  = mk_res(KIND_RECORD, record_address, type_value, 8'd0, ERR_NONE,
                           line_cur, 1'b0);
            res1  = mk_res(KIND_ERROR, 16'd0, 8'd0, 8'd0, ERR_END, line_cur, 1'b1);
            res_n = 2'd2;
          end
        end else begin
          res0  = mk_res(KIND_ERROR, 16'd0, 8'd0, 8'd0, ERR_END, line_cur, 1'b1);
          res_n = 2'd1;
        end
      end else begin
        unique case (phase)
          PH_COLON: begin
            if (!cmd.is_colon) begin
              res0  = mk_res(KIND_ERROR, 16'd0, 8'd0, 8'd0, ERR_COLON, line_cur, 1'b1);
              res_n = 2'd1;
            end
          end
          PH_LENGTH, PH_ADDRESS, PH_TYPE, PH_DATA, PH_CHECKSUM: begin
            if (!cmd.is_hex) begin
              res0  = mk_res(KIND_ERROR, 16'd0, 8'd0, 8'd0, ERR_HEX, line_cur, 1'b1);
              res_n = 2'd1;
            end else if (phase == PH_DATA && dl_dec == 3'd0) begin
              res0  = mk_res(KIND_DATA, record_address + {8'd0, data_index}, type_value,
                             v, ERR_NONE, line_cur, 1'b1);
              res_n = 2'd1;
            end
          end
          PH_NEWLINE: begin
            if (!(cmd.is_lf || cmd.is_cr)) begin
              res0  = mk_res(KIND_ERROR, 16'd0, 8'd0, 8'd0, ERR_NEWLINE, line_cur, 1'b1);
              res_n = 2'd1;
            end
          end
          PH_WHITE: begin
            if (!cmd.is_space) begin
              if (running_sum != 8'd0) begin
                res0  = mk_res(KIND_ERROR, record_address, type_value, 8'd0, ERR_CHECKSUM,
                               line_cur, 1'b1);
                res_n = 2'd1;
              end else if (type_value == TYPE_EOF || cmd.is_colon) begin
                res0  = mk_res(KIND_RECORD, record_address, type_value, 8'd0, ERR_NONE,
                               line_cur, 1'b1);
                res_n = 2'd1;
              end else begin
                res0  = mk_res(KIND_RECORD, record_address, type_value, 8'd0, ERR_NONE,
                               line_cur, 1'b0);
                res1  = mk_res(KIND_ERROR, 16'd0, 8'd0, 8'd0, ERR_COLON, line_cur, 1'b1);
                res_n = 2'd2;
              end
            end
          end
          default: res_n = 2'd0;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_COLON;
      digits_left    <= '0;
      accumulator    <= '0;
      record_length  <= '0;
      record_address <= '0;
      type_value     <= '0;
      data_index     <= '0;
      running_sum    <= '0;
      line_count     <= 16'd1;
      stopped        <= 1'b0;
    end else begin
      phase          <= phase_next;
      digits_left    <= digits_left_next;
      accumulator    <= accumulator_next;
      record_length  <= record_length_next;
      record_address <= record_address_next;
      type_value     <= type_value_next;
      data_index     <= data_index_next;
      running_sum    <= running_sum_next;
      line_count     <= line_count_next;
      stopped        <= stopped_next;
    end
  end

endmodule

// ===== src/hrp_result_queue.sv =====
// Result queue: takes up to two beats per cycle, gives one.
module hrp_result_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  res_n,
  input  hrp_pkg::res_t               res0,
  input  hrp_pkg::res_t               res1,
  output logic                        room,
  input  logic                        pop,
  output logic                        empty,
  output hrp_pkg::res_t               head,
  output logic [hrp_pkg::ResCntW-1:0] res_count
);
  import hrp_pkg::*;

  res_t               q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr;
  logic [ResPtrW-1:0] rd_ptr;
  logic [ResCntW-1:0] count;
  logic               give;

  // room for a two-beat burst, counted before this cycle's pop
  assign room      = (count <= ResCntW'(ResDepth - 2));
  assign empty     = (count == '0);
  assign give      = pop && !empty;
  assign head      = q[rd_ptr];
  assign res_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ResPtrW'(res_n);
      if (give) rd_ptr <= rd_ptr + ResPtrW'(1);
      count <= count + ResCntW'(res_n) - ResCntW'(give);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (res_n != 2'd0) q[wr_ptr] <= res0;
    if (res_n == 2'd2) q[wr_ptr + ResPtrW'(1)] <= res1;
  end

endmodule

// ===== src/hex_record_parser.sv =====
// Intel HEX record parser top level: front classifier, back parser, result queue.
//
// Input channel: one character (char_in) or an end-of-input mark (end_of_input)
// per beat, taken when push is high and full is low. Result channel: the oldest
// result stands on kind, byte_address, record_type, data_byte, error_code,
// line_number and last while empty is low; pop takes it.
// A character gives zero, one or two results; last marks the final one of it.
// Path: a taken character is written into the front queue; the parser steps on
// it when the result queue has room and writes its results into the result
// queue, whose head shows on the outputs.
// Throughput: one character per cycle while the consumer pops every cycle; the
// parser steps only when the result queue has room for two beats, so a
// character that gives two results can make it wait for the queue to drain.
// Stall: with pop low the result queue fills, the parser holds, the 4-entry
// front queue fills and full rises; nothing is lost.
// Reset (rst, synchronous): both queues empty, parser waits for a colon, line
// count 1. After an error or an accepted EOF record the parser is halted: it
// keeps taking characters but gives no results until reset.
module hex_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] byte_address,
  output logic [7:0]  record_type,
  output logic [7:0]  data_byte,
  output logic [2:0]  error_code,
  output logic [15:0] line_number,
  output logic        last
);
  import hrp_pkg::*;

  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;
  logic        room;
  logic [1:0]  res_n;
  res_t        res0;
  res_t        res1;
  res_t        head;
  hrp_status_t status;

  hrp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_in      (char_in),
    .end_of_input (end_of_input),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .cmd_count    (status.cmd_count)
  );

  hrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .room      (room),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  hrp_result_queue u_results (
    .clk       (clk),
    .rst       (rst),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .pop       (pop),
    .empty     (empty),
    .head      (head),
    .res_count (status.res_count)
  );

  assign kind         = head.kind;
  assign byte_address = head.byte_address;
  assign record_type  = head.record_type;
  assign data_byte    = head.data_byte;
  assign error_code   = head.error_code;
  assign line_number  = head.line_number;
  assign last         = head.last;

  // Checks
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (empty && !full && status.cmd_count == '0))
    else $error("queues not empty after reset");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    status.res_count <= ResCntW'(ResDepth))
    else $error("result queue overfilled");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_burst_room: assert property (@(posedge clk) disable iff (rst)
    (res_n != 2'd0) |-> room)
    else $error("results written without room");

endmodule

// ===== bench/tb_hex_record_parser.sv =====
// Self-checking testbench for the Intel HEX record parser.
`timescale 1ns / 1ps

module tb_hex_record_parser;
  import hrp_pkg::*;

  // ASCII codes the stimulus and the predictor care about
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 500;

  // How the text stream ends; after any of these the block halts
  typedef enum int {
    TERM_EOF_COLON, TERM_EOF_END, TERM_GOOD_END, TERM_BAD_SUM_COLON, TERM_GOOD_JUNK,
    TERM_NON_HEX, TERM_NO_NEWLINE, TERM_END_MID, TERM_BAD_SUM_END
  } ending_t;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         wait_drain;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_in = 8'h00;
  logic        end_of_input = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [15:0] byte_address;
  logic [7:0]  record_type;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;
  logic [15:0] line_number;
  logic        last;

  hex_record_parser uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_in(char_in),
    .end_of_input(end_of_input), .empty(empty), .pop(pop), .kind(kind),
    .byte_address(byte_address), .record_type(record_type), .data_byte(data_byte),
    .error_code(error_code), .line_number(line_number), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus and expectation stores
  char_beat_t char_feed[$];
  res_t       pending_results[$];
  res_t       step_out[$];
  logic [7:0] rec_text[$];
  bit         pause_next = 1'b0;

  // Parser shadow state
  phase_t      ph = PH_COLON;
  logic [2:0]  nib_left = '0;
  logic [15:0] acc = '0;
  logic [7:0]  rec_len = '0;
  logic [15:0] rec_addr = '0;
  logic [7:0]  rec_type = '0;
  logic [7:0]  data_idx = '0;
  logic [7:0]  csum = '0;
  logic [15:0] line_no = 16'd1;
  bit          halted = 1'b0;

  // Run statistics
  int beats_in = 0;
  int beats_out = 0;
  int data_seen = 0;
  int records_seen = 0;
  int errors_seen = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  ending_t ending;

  // ---------------------------------------------------------------- predictor

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic bit is_white(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic void emit(logic [1:0] k, logic [15:0] addr, logic [7:0] rtype,
                               logic [7:0] dbyte, logic [2:0] err);
    res_t r;
    r = {k, addr, rtype, dbyte, err, line_no, 1'b0};
    step_out.push_back(r);
  endfunction

  function automatic void raise_error(logic [2:0] err);
    emit(KIND_ERROR, 16'h0000, 8'h00, 8'h00, err);
    halted = 1'b1;
  endfunction

  function automatic void close_record();
    if (csum != 8'h00) begin
      emit(KIND_ERROR, rec_addr, rec_type, 8'h00, ERR_CHECKSUM);
      halted = 1'b1;
    end else begin
      emit(KIND_RECORD, rec_addr, rec_type, 8'h00, ERR_NONE);
      if (rec_type == TYPE_EOF) halted = 1'b1;
    end
  endfunction

  function automatic void want_colon(logic [7:0] c);
    if (c != CH_COLON) begin
      raise_error(ERR_COLON);
    end else begin
      ph = PH_LENGTH;
      nib_left = 3'd2;
      acc = '0;
      csum = '0;
    end
  endfunction

  // One hex digit of a numeric field; completes a field every 2 or 4 digits
  function automatic void take_nibble(logic [7:0] c);
    logic [15:0] v;
    int d;
    d = hex_nibble(c);
    if (d < 0) begin
      raise_error(ERR_HEX);
      return;
    end
    acc = {acc[11:0], d[3:0]};
    nib_left = nib_left - 3'd1;
    if (nib_left != 0) return;
    v = acc;
    acc = '0;
    nib_left = 3'd2;
    case (ph)
      PH_LENGTH: begin
        rec_len = v[7:0];
        csum = csum + v[7:0];
        ph = PH_ADDRESS;
        nib_left = 3'd4;
      end
      PH_ADDRESS: begin
        rec_addr = v;
        csum = csum + v[15:8] + v[7:0];
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        rec_type = v[7:0];
        csum = csum + v[7:0];
        data_idx = '0;
        ph = (rec_len == 8'h00) ? PH_CHECKSUM : PH_DATA;
      end
      PH_DATA: begin
        emit(KIND_DATA, rec_addr + {8'h00, data_idx}, rec_type, v[7:0], ERR_NONE);
        csum = csum + v[7:0];
        data_idx = data_idx + 8'd1;
        if (data_idx == rec_len) ph = PH_CHECKSUM;
      end
      default: begin
        csum = csum + v[7:0];
        ph = PH_NEWLINE;
      end
    endcase
  endfunction

  // Advance the shadow parser by one accepted beat and queue what it yields
  function automatic void hex_parse_step(logic [7:0] c, logic eoi);
    res_t r;
    int n;
    step_out.delete();
    if (!halted) begin
      if (eoi) begin
        if (ph == PH_WHITE) begin
          close_record();
          if (!halted) raise_error(ERR_END);
        end else begin
          raise_error(ERR_END);
        end
      end else begin
        if (c == CH_LF && line_no != LINE_MAX) line_no = line_no + 16'd1;
        case (ph)
          PH_COLON: want_colon(c);
          PH_NEWLINE: begin
            if (c == CH_LF || c == CH_CR) ph = PH_WHITE;
            else raise_error(ERR_NEWLINE);
          end
          PH_WHITE: begin
            if (!is_white(c)) begin
              close_record();
              if (!halted) want_colon(c);
            end
          end
          default: take_nibble(c);
        endcase
      end
    end
    n = step_out.size();
    if (n > 0) begin
      r = step_out[n-1];
      r.last = 1'b1;
      step_out[n-1] = r;
    end
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  task automatic put_char(input logic [7:0] c, input logic eoi);
    char_beat_t b;
    b.ch = c;
    b.eoi = eoi;
    b.wait_drain = pause_next;
    pause_next = 1'b0;
    char_feed.push_back(b);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  task automatic add_hex(input logic [7:0] b);
    rec_text.push_back(hex_char(b[7:4]));
    rec_text.push_back(hex_char(b[3:0]));
  endtask

  // Record text from colon through checksum, in mixed-case hex
  task automatic build_record(input int len, input logic [15:0] addr,
                              input logic [7:0] rtype, input bit rails_fill,
                              input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    rec_text.delete();
    rec_text.push_back(CH_COLON);
    sum = len[7:0] + addr[15:8] + addr[7:0] + rtype;
    add_hex(len[7:0]);
    add_hex(addr[15:8]);
    add_hex(addr[7:0]);
    add_hex(rtype);
    for (i = 0; i < len; i++) begin
      b = rails_fill ? (i[0] ? 8'hff : 8'h00) : 8'($urandom_range(0, 255));
      add_hex(b);
      sum = sum + b;
    end
    sum = 8'h00 - sum;
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    add_hex(sum);
  endtask

  task automatic feed_text(input int count);
    int i;
    for (i = 0; i < count; i++) put_char(rec_text[i], 1'b0);
  endtask

  // CR, LF or CRLF, then a little whitespace of any kind
  task automatic end_line();
    logic [7:0] ws[6];
    int i, n;
    ws = '{CH_SPACE, 8'h09, CH_LF, 8'h0b, 8'h0c, CH_CR};
    case ($urandom_range(0, 2))
      0: put_char(CH_LF, 1'b0);
      1: put_char(CH_CR, 1'b0);
      default: begin
        put_char(CH_CR, 1'b0);
        put_char(CH_LF, 1'b0);
      end
    endcase
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) put_char(ws[$urandom_range(0, 5)], 1'b0);
  endtask

  function automatic logic [7:0] plain_type();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    return (t == TYPE_EOF) ? 8'h00 : t;
  endfunction

  task automatic random_record(input int len, input logic [15:0] addr);
    build_record(len, addr, plain_type(), 1'b0, 1'b0);
    feed_text(rec_text.size());
    end_line();
  endtask

  // ---------------------------------------------------------------- driver

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : feed_driver
    bit offer;
    if (rst) begin
      push <= 1'b0;
      char_in <= 8'h00;
      end_of_input <= 1'b0;
    end else begin
      if (push && !full) begin
        hex_parse_step(char_in, end_of_input);
        char_feed.delete(0);
        beats_in++;
      end
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (char_feed.size() != 0 &&
                   !(char_feed[0].wait_drain && pending_results.size() != 0)) begin
        offer = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(150, 400)
                                                  : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 6);
        end
      end
      push <= offer;
      if (offer) begin
        char_in <= char_feed[0].ch;
        end_of_input <= char_feed[0].eoi;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int stall_mode = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin : result_monitor
    res_t want, got;
    bit take;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {kind, byte_address, record_type, data_byte, error_code, line_number, last};
        beats_out++;
        case (kind)
          KIND_DATA:   data_seen++;
          KIND_RECORD: records_seen++;
          default:     errors_seen++;
        endcase
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing expected: kind=%0d addr=%h err=%0d",
                     $realtime, kind, byte_address, error_code);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch on result beat %0d", $realtime, beats_out);
              $display("  expected kind=%0d addr=%h type=%h data=%h err=%0d line=%0d last=%0b",
                       want.kind, want.byte_address, want.record_type, want.data_byte,
                       want.error_code, want.line_number, want.last);
              $display("  actual   kind=%0d addr=%h type=%h data=%h err=%0d line=%0d last=%0b",
                       kind, byte_address, record_type, data_byte, error_code,
                       line_number, last);
            end
          end
        end
      end

      // stall pattern: a pop mode redrawn at random, one long hold-off early on
      rx_cycle++;
      if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (!long_hold_done && beats_out >= 100) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (stall_mode)
          0: take = 1'b1;
          1: take = $urandom_range(0, 1);
          2: take = (rx_cycle % 4 == 0);
          default: take = ($urandom_range(0, 7) == 0);
        endcase
      end
      pop <= take;
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_sequence
    logic [7:0] c;
    int r, k;

    // directed: empty record at the top address with type FF
    build_record(0, 16'hffff, 8'hff, 1'b0, 1'b0);
    feed_text(rec_text.size());
    put_char(CH_LF, 1'b0);
    // data 00/FF with the address wrapping, CR then every whitespace code
    build_record(2, 16'hffff, 8'h00, 1'b1, 1'b0);
    feed_text(rec_text.size());
    put_char(CH_CR, 1'b0);
    put_char(CH_SPACE, 1'b0);
    put_char(8'h09, 1'b0);
    put_char(CH_LF, 1'b0);
    put_char(8'h0b, 1'b0);
    put_char(8'h0c, 1'b0);
    put_char(CH_CR, 1'b0);

    // random well-formed records, a few long ones
    r = 0;
    while (char_feed.size() < 830) begin
      if (r == 2 || $urandom_range(0, 7) == 0) pause_next = 1'b1;
      if (r == 4) random_record(255, 16'($urandom_range(0, 65535)));
      else if (r == 9) random_record(128, 16'hffc0);
      else random_record($urandom_range(0, 16), 16'($urandom_range(0, 65535)));
      r++;
    end

    // a few more short records before the ending
    for (k = 0; k < 4; k++) random_record($urandom_range(0, 8), 16'($urandom_range(0, 65535)));

    // one halting ending per run
    ending = ending_t'($urandom_range(0, 8));
    pause_next = ($urandom_range(0, 1) == 1);
    case (ending)
      TERM_EOF_COLON, TERM_EOF_END:
        build_record($urandom_range(0, 2), 16'($urandom_range(0, 65535)), TYPE_EOF,
                     1'b0, 1'b0);
      TERM_BAD_SUM_COLON, TERM_BAD_SUM_END:
        build_record($urandom_range(0, 6), 16'($urandom_range(0, 65535)), plain_type(),
                     1'b0, 1'b1);
      default:
        build_record($urandom_range(0, 6), 16'($urandom_range(0, 65535)), plain_type(),
                     1'b0, 1'b0);
    endcase
    case (ending)
      TERM_EOF_COLON, TERM_BAD_SUM_COLON: begin
        feed_text(rec_text.size());
        end_line();
        put_char(CH_COLON, 1'b0);
      end
      TERM_EOF_END, TERM_GOOD_END, TERM_BAD_SUM_END: begin
        feed_text(rec_text.size());
        end_line();
        put_char(8'($urandom_range(0, 255)), 1'b1);
      end
      TERM_GOOD_JUNK: begin
        feed_text(rec_text.size());
        end_line();
        do c = 8'($urandom_range(0, 255)); while (c == CH_COLON || is_white(c));
        put_char(c, 1'b0);
      end
      TERM_NON_HEX: begin
        feed_text($urandom_range(1, rec_text.size() - 1));
        if ($urandom_range(0, 3) == 0) c = CH_LF;
        else do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        put_char(c, 1'b0);
      end
      TERM_NO_NEWLINE: begin
        feed_text(rec_text.size());
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
        put_char(c, 1'b0);
      end
      default: begin
        feed_text($urandom_range(1, rec_text.size()));
        put_char(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase

    // halted: anything after this must give no result
    for (k = 0; k < 40; k++)
      put_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (char_feed.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!empty) begin
      fail_count++;
      $display("result left on the outputs after the stream was done");
    end

    $display("Fed %0d characters (ending %s); checked %0d result beats:",
             beats_in, ending.name(), beats_out);
    $display("  %0d data bytes, %0d records, %0d errors; %0d failures",
             data_seen, records_seen, errors_seen, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
